### sv/box_mean_filter_macros.svh
// Assertion macros shared by the box mean filter RTL.
`ifndef BOX_MEAN_FILTER_MACROS_SVH
`define BOX_MEAN_FILTER_MACROS_SVH
`ifndef ASSERT_OFF
`define BMF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("box_mean_filter: assertion failed");
`define BMF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("box_mean_filter: assertion failed");
`else
`define BMF_ASSERT_IMP(lbl, ante, cons)
`define BMF_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### sv/bmf_pkg.sv
`default_nettype none

package bmf_pkg;

    localparam int NCH        = 3;
    localparam int PIX_W      = 8;
    localparam int SUM_W      = 14;
    localparam int QUO_W      = 8;
    localparam int AREA_W     = 6;
    localparam int OFS_W      = 3;
    localparam int ROW_W      = 12;
    localparam int HGT_W      = 13;
    localparam int WID_W      = 11;
    localparam int KRN_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_HALF_W = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_HALF_H = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE   = 3'd4;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // One stage of the restoring divider chain
    typedef struct packed {
        logic                           valid;
        logic                           last;
        logic                           color;
        logic [SUM_W-1:0]               dvs;
        logic [NCH-1:0][SUM_W-1:0]      rem;
        logic [NCH-1:0][QUO_W-1:0]      quo;
    } div_stage_t;

endpackage

`default_nettype wire

### sv/bmf_div_cell.sv
`default_nettype none

module bmf_div_cell (
    input  wire                     clk,
    input  wire                     rst_n,
    input  bmf_pkg::div_stage_t     stage_in,
    output bmf_pkg::div_stage_t     stage_out
);
    import bmf_pkg::*;

    div_stage_t stage_reg;
    div_stage_t stage_next;

    always_comb
    begin
        stage_next = stage_in;
        for (int ch = 0; ch < NCH; ch++)
        begin
            if (stage_in.rem[ch] >= stage_in.dvs)
            begin
                stage_next.rem[ch] = stage_in.rem[ch] - stage_in.dvs;
                stage_next.quo[ch] = {stage_in.quo[ch][QUO_W-2:0], 1'b1};
            end
            else
            begin
                stage_next.quo[ch] = {stage_in.quo[ch][QUO_W-2:0], 1'b0};
            end
        end
        // neighbor tests the next lower quotient bit
        stage_next.dvs = stage_in.dvs >> 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

`default_nettype wire

### sv/box_mean_filter.sv
// Box mean filter, reflect-101 borders, raster pixel stream.
// Input channel (in_valid/in_ready): opcode 0 carries a pixel, opcode 1 is a
// drain request. Each request releases at most one output pixel, in raster
// order, once every pixel of its window is in; drain requests after the
// frame push out the rest, and frame_last marks the final output.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): write only while
// idle; any write to a known register restarts the frame counters.
// Flow: a request that releases a pixel makes one line-store read per window
// tap through the single read port, then passes through the divider chain
// (one quotient bit per cell). One request is in flight at a time.
// The result sits in an output register; the next request is taken while
// it waits, and a new result is launched only after the old one is taken.
// Reset: registers return to 1024x480, 3x3 window, gray mode, counters zero.
// The line store is not cleared; every read hits a pixel of the same frame.
`default_nettype none
`include "box_mean_filter_macros.svh"

module box_mean_filter #(
    parameter int MAX_WIDTH       = 1024,
    parameter int MAX_HALF_KERNEL = 3,
    parameter int STORE_ROWS      = 8
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 in_valid,
    output logic                                in_ready,
    input  wire                                 opcode,
    input  wire  [bmf_pkg::PIX_W-1:0]           pix_c0,
    input  wire  [bmf_pkg::PIX_W-1:0]           pix_c1,
    input  wire  [bmf_pkg::PIX_W-1:0]           pix_c2,
    output logic                                out_valid,
    input  wire                                 out_ready,
    output logic [bmf_pkg::PIX_W-1:0]           res_c0,
    output logic [bmf_pkg::PIX_W-1:0]           res_c1,
    output logic [bmf_pkg::PIX_W-1:0]           res_c2,
    output logic                                frame_last,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [bmf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [bmf_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import bmf_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int SW    = $clog2(STORE_ROWS);
    localparam int AW    = SW + CW;
    localparam int DEPTH = STORE_ROWS * (2 ** CW);
    localparam int XW    = CW + 3;
    localparam int YW    = HGT_W + 2;
    localparam int B_CAP = (MAX_HALF_KERNEL < (STORE_ROWS - 2) / 2) ?
                           MAX_HALF_KERNEL : (STORE_ROWS - 2) / 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SUM,
        ST_FLUSH,
        ST_LAUNCH,
        ST_WAIT
    } state_t;

    state_t                     state_reg;
    logic [WID_W-1:0]           width_reg;
    logic [HGT_W-1:0]           height_reg;
    logic [KRN_W-1:0]           khw_reg;
    logic [KRN_W-1:0]           khh_reg;
    logic                       color_reg;

    logic [CW-1:0]              in_col_reg;
    logic [HGT_W-1:0]           in_row_reg;
    logic [SW-1:0]              in_slot_reg;
    logic                       in_done_reg;
    logic [CW-1:0]              out_col_reg;
    logic [ROW_W-1:0]           out_row_reg;
    logic [SW-1:0]              out_slot_reg;

    logic signed [OFS_W-1:0]    dr_reg;
    logic signed [OFS_W-1:0]    dc_reg;
    logic                       rd_valid_reg;
    logic [NCH-1:0][SUM_W-1:0]  acc_reg;
    logic                       last_reg;

    logic                       out_valid_reg;
    logic [NCH-1:0][PIX_W-1:0]  res_reg;
    logic                       frame_last_reg;

    logic [NCH*PIX_W-1:0]       mem [DEPTH];
    logic [NCH*PIX_W-1:0]       rd_data_reg;

    // effective (clamped) configuration
    logic [WW-1:0]              w_eff;
    logic [HGT_W-1:0]           h_eff;
    logic [KRN_W-1:0]           a_eff;
    logic [KRN_W-1:0]           b_eff;

    always_comb
    begin
        if (width_reg < WID_W'(4))
            w_eff = WW'(4);
        else if (int'(width_reg) > MAX_WIDTH)
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(width_reg);

        if (height_reg < HGT_W'(4))
            h_eff = HGT_W'(4);
        else if (height_reg > HGT_W'(4096))
            h_eff = HGT_W'(4096);
        else
            h_eff = height_reg;

        if (int'(khw_reg) > MAX_HALF_KERNEL)
            a_eff = KRN_W'(MAX_HALF_KERNEL);
        else
            a_eff = khw_reg;

        if (int'(khh_reg) > B_CAP)
            b_eff = KRN_W'(B_CAP);
        else
            b_eff = khh_reg;
    end

    // line store write side
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [NCH*PIX_W-1:0]       wr_data;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign wr_en     = in_valid && in_ready && (opcode == OP_PIXEL) && !in_done_reg;
    assign wr_addr   = {in_slot_reg, in_col_reg};
    assign wr_data   = color_reg ? {pix_c2, pix_c1, pix_c0} : {{(2*PIX_W){1'b0}}, pix_c0};

    // release check
    logic [HGT_W-1:0]           hm1;
    logic [HGT_W-1:0]           nr;
    logic [CW:0]                wm1c;
    logic [CW:0]                nc;
    logic                       out_ready_c;
    logic                       last_c;

    always_comb
    begin
        hm1  = h_eff - HGT_W'(1);
        nr   = HGT_W'(out_row_reg) + HGT_W'(b_eff);
        if (nr > hm1)
            nr = hm1;
        wm1c = (CW+1)'(w_eff) - (CW+1)'(1);
        nc   = (CW+1)'(out_col_reg) + (CW+1)'(a_eff);
        if (nc > wm1c)
            nc = wm1c;
        out_ready_c = in_done_reg || (in_row_reg > nr) ||
                      ((in_row_reg == nr) && ((CW+1)'(in_col_reg) > nc));
        last_c = (HGT_W'(out_row_reg) == hm1) && ((CW+1)'(out_col_reg) == wm1c);
    end

    // window tap address with reflect-101 fold
    logic signed [XW-1:0]       xc;
    logic signed [XW-1:0]       wm1s;
    logic signed [XW-1:0]       col_x;
    logic signed [YW-1:0]       xr;
    logic signed [YW-1:0]       hm1s;
    logic signed [YW-1:0]       row_x;
    logic signed [YW-1:0]       drow;
    logic signed [SW+1:0]       slot_s;
    logic [AW-1:0]              rd_addr;

    always_comb
    begin
        xc   = signed'(XW'(out_col_reg)) + XW'(dc_reg);
        wm1s = signed'(XW'(w_eff)) - XW'(1);
        if (xc < XW'(0))
            col_x = -xc;
        else if (xc > wm1s)
            col_x = (wm1s <<< 1) - xc;
        else
            col_x = xc;

        xr   = signed'(YW'(out_row_reg)) + YW'(dr_reg);
        hm1s = signed'(YW'(h_eff)) - YW'(1);
        if (xr < YW'(0))
            row_x = -xr;
        else if (xr > hm1s)
            row_x = (hm1s <<< 1) - xr;
        else
            row_x = xr;

        // folded row stays within the window, so its slot is a small offset
        drow   = row_x - signed'(YW'(out_row_reg));
        slot_s = signed'((SW+2)'(out_slot_reg)) + (SW+2)'(signed'(drow[OFS_W-1:0]));
        if (slot_s < (SW+2)'(0))
            slot_s = slot_s + (SW+2)'(STORE_ROWS);
        else if (slot_s >= (SW+2)'(STORE_ROWS))
            slot_s = slot_s - (SW+2)'(STORE_ROWS);

        rd_addr = {slot_s[SW-1:0], col_x[CW-1:0]};
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    // divider chain
    div_stage_t                 chain [QUO_W+1];
    logic [QUO_W-1:0]           chain_valid;
    logic [AREA_W-1:0]          area;

    assign area = AREA_W'({a_eff, 1'b1}) * AREA_W'({b_eff, 1'b1});

    always_comb
    begin
        chain[0].valid = (state_reg == ST_LAUNCH) && !out_valid_reg;
        chain[0].last  = last_reg;
        chain[0].color = color_reg;
        chain[0].dvs   = SUM_W'(area) << (QUO_W - 1);
        chain[0].rem   = acc_reg;
        chain[0].quo   = '0;
    end

    for (genvar g = 0; g < QUO_W; g++)
    begin : g_cell
        bmf_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage_in  (chain[g]),
            .stage_out (chain[g+1])
        );
        assign chain_valid[g] = chain[g+1].valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            width_reg      <= WID_W'(1024);
            height_reg     <= HGT_W'(480);
            khw_reg        <= KRN_W'(1);
            khh_reg        <= KRN_W'(1);
            color_reg      <= 1'b0;
            in_col_reg     <= '0;
            in_row_reg     <= '0;
            in_slot_reg    <= '0;
            in_done_reg    <= 1'b0;
            out_col_reg    <= '0;
            out_row_reg    <= '0;
            out_slot_reg   <= '0;
            dr_reg         <= '0;
            dc_reg         <= '0;
            rd_valid_reg   <= 1'b0;
            acc_reg        <= '0;
            last_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            res_reg        <= '0;
            frame_last_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= (state_reg == ST_SUM);
            if (rd_valid_reg)
            begin
                for (int ch = 0; ch < NCH; ch++)
                    acc_reg[ch] <= acc_reg[ch] + SUM_W'(rd_data_reg[ch*PIX_W +: PIX_W]);
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:   width_reg  <= cfg_data[WID_W-1:0];
                    REG_IMAGE_HEIGHT:  height_reg <= cfg_data[HGT_W-1:0];
                    REG_KERNEL_HALF_W: khw_reg    <= cfg_data[KRN_W-1:0];
                    REG_KERNEL_HALF_H: khh_reg    <= cfg_data[KRN_W-1:0];
                    REG_COLOR_MODE:    color_reg  <= cfg_data[0];
                    default:           ;
                endcase
                if (cfg_index <= REG_COLOR_MODE)
                begin
                    in_col_reg   <= '0;
                    in_row_reg   <= '0;
                    in_slot_reg  <= '0;
                    in_done_reg  <= 1'b0;
                    out_col_reg  <= '0;
                    out_row_reg  <= '0;
                    out_slot_reg <= '0;
                end
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (wr_en)
                        begin
                            if ((CW+1)'(in_col_reg) + (CW+1)'(1) >= (CW+1)'(w_eff))
                            begin
                                in_col_reg <= '0;
                                in_row_reg <= in_row_reg + HGT_W'(1);
                                if (in_slot_reg == SW'(STORE_ROWS - 1))
                                    in_slot_reg <= '0;
                                else
                                    in_slot_reg <= in_slot_reg + SW'(1);
                                if (in_row_reg + HGT_W'(1) >= h_eff)
                                    in_done_reg <= 1'b1;
                            end
                            else
                            begin
                                in_col_reg <= in_col_reg + CW'(1);
                            end
                        end
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    if (out_ready_c)
                    begin
                        dr_reg    <= -signed'(OFS_W'(b_eff));
                        dc_reg    <= -signed'(OFS_W'(a_eff));
                        acc_reg   <= '0;
                        last_reg  <= last_c;
                        state_reg <= ST_SUM;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_SUM:
                begin
                    if (dc_reg == signed'(OFS_W'(a_eff)))
                    begin
                        dc_reg <= -signed'(OFS_W'(a_eff));
                        if (dr_reg == signed'(OFS_W'(b_eff)))
                            state_reg <= ST_FLUSH;
                        else
                            dr_reg <= dr_reg + OFS_W'(1);
                    end
                    else
                    begin
                        dc_reg <= dc_reg + OFS_W'(1);
                    end
                end
                ST_FLUSH:
                begin
                    state_reg <= ST_LAUNCH;
                end
                ST_LAUNCH:
                begin
                    if (!out_valid_reg)
                    begin
                        state_reg <= ST_WAIT;
                        if (last_reg)
                        begin
                            in_col_reg   <= '0;
                            in_row_reg   <= '0;
                            in_slot_reg  <= '0;
                            in_done_reg  <= 1'b0;
                            out_col_reg  <= '0;
                            out_row_reg  <= '0;
                            out_slot_reg <= '0;
                        end
                        else if ((CW+1)'(out_col_reg) + (CW+1)'(1) >= (CW+1)'(w_eff))
                        begin
                            out_col_reg <= '0;
                            out_row_reg <= out_row_reg + ROW_W'(1);
                            if (out_slot_reg == SW'(STORE_ROWS - 1))
                                out_slot_reg <= '0;
                            else
                                out_slot_reg <= out_slot_reg + SW'(1);
                        end
                        else
                        begin
                            out_col_reg <= out_col_reg + CW'(1);
                        end
                    end
                end
                ST_WAIT:
                begin
                    if (chain[QUO_W].valid)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (chain[QUO_W].valid)
            begin
                out_valid_reg  <= 1'b1;
                res_reg[0]     <= chain[QUO_W].quo[0];
                res_reg[1]     <= chain[QUO_W].color ? chain[QUO_W].quo[1] : '0;
                res_reg[2]     <= chain[QUO_W].color ? chain[QUO_W].quo[2] : '0;
                frame_last_reg <= chain[QUO_W].last;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign res_c0     = res_reg[0];
    assign res_c1     = res_reg[1];
    assign res_c2     = res_reg[2];
    assign frame_last = frame_last_reg;

    `BMF_ASSERT_IMP(a_tail_slot_free, chain[QUO_W].valid, !out_valid_reg)
    `BMF_ASSERT_IMP(a_one_in_chain, 1'b1, $countones(chain_valid) <= 1)
    `BMF_ASSERT_IMP(a_idle_chain_empty, state_reg == ST_IDLE, chain_valid == '0)
    `BMF_ASSERT_NXT(a_read_follows_sum, state_reg == ST_SUM, rd_valid_reg)

endmodule

`default_nettype wire
